/* rtl/cils_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cils_pkg;

    localparam int LEVELS       = 4;
    localparam int NUM_THRESH   = 10;
    localparam int IDX_W        = 6;   // ring index, depths up to 64
    localparam int FILL_W       = 7;   // fill count, holds the depth itself

    localparam int DEF_PULSE_DEPTH  = 4;
    localparam int DEF_SECOND_DEPTH = 60;
    localparam int DEF_MINUTE_DEPTH = 60;
    localparam int DEF_HOUR_DEPTH   = 24;
    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int DEF_COUNTER_BITS = 32;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 120;

    localparam logic       OP_LOG  = 1'b0;
    localparam logic [1:0] LV_HOUR = 2'd3;

    // thresholds in hundredths of a percent
    localparam logic [31:0] THRESH_HUNDREDTHS [NUM_THRESH] = '{
        32'd1000, 32'd3000, 32'd5000, 32'd7000, 32'd9000,
        32'd10000, 32'd25000, 32'd50000, 32'd100000, 32'd250000
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOG,
        ST_ADD,
        ST_WSTART,
        ST_WALK,
        ST_DSTART,
        ST_DIV,
        ST_PROMOTE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic log_update;
        logic add_write;
        logic walk_start;
        logic walk_report;
        logic rd_issue;
        logic div_start;
        logic div_step;
        logic promote;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_log;
        logic wrap_up;
        logic walk_more;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* rtl/cils_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module cils_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire cils_pkg::status_t st,
    output cils_pkg::cmd_t        cmd
);

    cils_pkg::state_t state_reg, state_next;
    logic report_reg, report_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cils_pkg::ST_IDLE;
            report_reg <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            report_reg <= report_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        report_next = report_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        case (state_reg)
            cils_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid)
                    state_next = cils_pkg::ST_LOG;
            end
            cils_pkg::ST_LOG:
            begin
                if (st.is_log)
                begin
                    cmd.log_update = 1'b1;
                    state_next     = cils_pkg::ST_ADD;
                end
                else
                begin
                    report_next = 1'b1;
                    state_next  = cils_pkg::ST_WSTART;
                end
            end
            cils_pkg::ST_ADD:
            begin
                cmd.add_write = 1'b1;
                report_next   = !st.wrap_up;
                state_next    = cils_pkg::ST_WSTART;
            end
            cils_pkg::ST_WSTART:
            begin
                cmd.walk_start  = 1'b1;
                cmd.walk_report = report_reg;
                state_next      = cils_pkg::ST_WALK;
            end
            cils_pkg::ST_WALK:
            begin
                if (st.walk_more)
                    cmd.rd_issue = 1'b1;
                else
                    state_next = cils_pkg::ST_DSTART;
            end
            cils_pkg::ST_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = cils_pkg::ST_DIV;
            end
            cils_pkg::ST_DIV:
            begin
                if (st.div_done)
                    state_next = report_reg ? cils_pkg::ST_OUT : cils_pkg::ST_PROMOTE;
                else
                    cmd.div_step = 1'b1;
            end
            cils_pkg::ST_PROMOTE:
            begin
                cmd.promote = 1'b1;
                state_next  = cils_pkg::ST_ADD;
            end
            cils_pkg::ST_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = cils_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cils_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/cils_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module cils_dp #(
    parameter int PULSE_DEPTH  = cils_pkg::DEF_PULSE_DEPTH,
    parameter int SECOND_DEPTH = cils_pkg::DEF_SECOND_DEPTH,
    parameter int MINUTE_DEPTH = cils_pkg::DEF_MINUTE_DEPTH,
    parameter int HOUR_DEPTH   = cils_pkg::DEF_HOUR_DEPTH,
    parameter int SAMPLE_BITS  = cils_pkg::DEF_SAMPLE_BITS,
    parameter int COUNTER_BITS = cils_pkg::DEF_COUNTER_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire cils_pkg::cmd_t                  cmd,
    output cils_pkg::status_t                    st,
    input  wire logic [cils_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic [cils_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [cils_pkg::OUT_DATA_W-1:0]      m_tdata
);

    localparam int SB     = SAMPLE_BITS;
    localparam int CB     = COUNTER_BITS;
    localparam int SUM_W  = SB + cils_pkg::IDX_W;
    localparam int DCNT_W = $clog2(SUM_W + 1);
    localparam int IW     = cils_pkg::IDX_W;
    localparam int FW     = cils_pkg::FILL_W;

    // input word latch
    logic          op_reg;
    logic [SB-1:0] samp_reg;
    logic [1:0]    req_lv_reg;
    logic [3:0]    tidx_reg;

    logic [SB+15:0] samp_wide;
    assign samp_wide = {{SB{1'b0}}, s_tdata[15:0]};

    // architectural state
    logic [SB-1:0] last_reg, peak_reg;
    logic [CB-1:0] hit_reg [cils_pkg::NUM_THRESH];
    logic [IW-1:0] pos_reg [cils_pkg::LEVELS];
    logic [FW-1:0] fill_reg [cils_pkg::LEVELS];

    // entry being inserted into the cascade
    logic [1:0]    cur_lv_reg;
    logic [SB-1:0] ent_avg_reg, ent_min_reg, ent_max_reg;

    // ring storage: {level, index} addressed, fields avg/min/max
    logic [3*SB-1:0] mem [cils_pkg::LEVELS * (2 ** IW)];
    logic [3*SB-1:0] rd_data_reg;

    // statistics walk
    logic [1:0]       walk_lv_reg;
    logic [FW-1:0]    walk_n_reg;
    logic [FW-1:0]    idx_reg;
    logic             rd_vld_reg, rd_first_reg;
    logic [SUM_W-1:0] acc_sum_reg;
    logic [SB-1:0]    acc_min_reg, acc_max_reg;

    // bit-serial divider
    logic [SUM_W-1:0]  div_q_reg;
    logic [IW-1:0]     div_rem_reg;
    logic [DCNT_W-1:0] div_cnt_reg;

    logic                          m_tvalid_reg;
    logic [cils_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    function automatic logic [FW-1:0] depth_of(input logic [1:0] lv);
        case (lv)
            2'd0:    depth_of = FW'(PULSE_DEPTH);
            2'd1:    depth_of = FW'(SECOND_DEPTH);
            2'd2:    depth_of = FW'(MINUTE_DEPTH);
            default: depth_of = FW'(HOUR_DEPTH);
        endcase
    endfunction

    logic [IW-1:0] cur_pos;
    logic [FW-1:0] cur_pos_inc, cur_depth;
    assign cur_pos     = pos_reg[cur_lv_reg];
    assign cur_pos_inc = {1'b0, cur_pos} + FW'(1);
    assign cur_depth   = depth_of(cur_lv_reg);

    logic [IW:0] div_shift;
    logic        div_ge;
    assign div_shift = {div_rem_reg, div_q_reg[SUM_W-1]};
    assign div_ge    = div_shift >= walk_n_reg;

    logic [SB-1:0] avg_res;
    assign avg_res = (walk_n_reg == '0) ? '0 : div_q_reg[SB-1:0];

    logic [SB-1:0] rd_avg, rd_min, rd_max;
    assign rd_avg = rd_data_reg[SB-1:0];
    assign rd_min = rd_data_reg[2*SB-1:SB];
    assign rd_max = rd_data_reg[3*SB-1:2*SB];

    logic [SB+31:0] samp_cmp;
    assign samp_cmp = {32'b0, samp_reg};

    assign st.is_log    = (op_reg == cils_pkg::OP_LOG);
    assign st.wrap_up   = (cur_pos_inc >= cur_depth) && (cur_lv_reg != cils_pkg::LV_HOUR);
    assign st.walk_more = idx_reg < walk_n_reg;
    assign st.div_done  = (div_cnt_reg == '0);
    assign st.out_free  = !m_tvalid_reg || m_tready;

    // output field resizing
    logic [SB+15:0] avg_w, min_w, max_w, last_w, peak_w;
    logic [CB+31:0] hits_w;
    logic [CB-1:0]  hits_sel;
    assign avg_w    = {16'b0, avg_res};
    assign min_w    = {16'b0, acc_min_reg};
    assign max_w    = {16'b0, acc_max_reg};
    assign last_w   = {16'b0, last_reg};
    assign peak_w   = {16'b0, peak_reg};
    assign hits_sel = (tidx_reg < 4'(cils_pkg::NUM_THRESH)) ? hit_reg[tidx_reg] : '0;
    assign hits_w   = {32'b0, hits_sel};

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= s_tuser[0];
            samp_reg   <= samp_wide[SB-1:0];
            req_lv_reg <= s_tdata[17:16];
            tidx_reg   <= s_tdata[21:18];
        end
        if (cmd.add_write)
            mem[{cur_lv_reg, cur_pos}] <= {ent_max_reg, ent_min_reg, ent_avg_reg};
        if (cmd.rd_issue)
            rd_data_reg <= mem[{walk_lv_reg, idx_reg[IW-1:0]}];
        if (cmd.log_update)
        begin
            ent_avg_reg <= samp_reg;
            ent_min_reg <= samp_reg;
            ent_max_reg <= samp_reg;
        end
        else if (cmd.promote)
        begin
            ent_avg_reg <= avg_res;
            ent_min_reg <= acc_min_reg;
            ent_max_reg <= acc_max_reg;
        end
        if (cmd.walk_start)
        begin
            walk_lv_reg <= cmd.walk_report ? req_lv_reg : cur_lv_reg;
            walk_n_reg  <= fill_reg[cmd.walk_report ? req_lv_reg : cur_lv_reg];
            acc_sum_reg <= '0;
            acc_min_reg <= '0;
            acc_max_reg <= '0;
        end
        else if (rd_vld_reg)
        begin
            acc_sum_reg <= acc_sum_reg + SUM_W'(rd_avg);
            if (rd_first_reg || rd_min < acc_min_reg)
                acc_min_reg <= rd_min;
            if (rd_max > acc_max_reg)
                acc_max_reg <= rd_max;
        end
        if (cmd.rd_issue)
            rd_first_reg <= (idx_reg == '0);
        if (cmd.div_start)
        begin
            div_q_reg   <= acc_sum_reg;
            div_rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_q_reg   <= {div_q_reg[SUM_W-2:0], div_ge};
            div_rem_reg <= div_ge ? IW'(div_shift - walk_n_reg) : div_shift[IW-1:0];
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= {2'b00, hits_w[31:0], peak_w[15:0], last_w[15:0],
                            max_w[15:0], min_w[15:0], avg_w[15:0],
                            fill_reg[req_lv_reg][5:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg     <= '0;
            peak_reg     <= '0;
            cur_lv_reg   <= '0;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < cils_pkg::NUM_THRESH; i++)
                hit_reg[i] <= '0;
            for (int l = 0; l < cils_pkg::LEVELS; l++)
            begin
                pos_reg[l]  <= '0;
                fill_reg[l] <= '0;
            end
        end
        else
        begin
            rd_vld_reg <= cmd.rd_issue;
            if (cmd.log_update)
            begin
                last_reg   <= samp_reg;
                cur_lv_reg <= '0;
                if (samp_reg > peak_reg)
                    peak_reg <= samp_reg;
                // thresholds ascend, so every exceeded one lies below the first miss
                for (int i = 0; i < cils_pkg::NUM_THRESH; i++)
                begin
                    if (samp_cmp > {{SB{1'b0}}, cils_pkg::THRESH_HUNDREDTHS[i]}
                        && hit_reg[i] != '1)
                        hit_reg[i] <= hit_reg[i] + CB'(1);
                end
            end
            else if (cmd.promote)
                cur_lv_reg <= cur_lv_reg + 2'd1;
            if (cmd.add_write)
            begin
                if (fill_reg[cur_lv_reg] <= {1'b0, cur_pos})
                    fill_reg[cur_lv_reg] <= cur_pos_inc;
                pos_reg[cur_lv_reg] <= (cur_pos_inc < cur_depth) ? cur_pos_inc[IW-1:0] : '0;
            end
            if (cmd.walk_start)
                idx_reg <= '0;
            else if (cmd.rd_issue)
                idx_reg <= idx_reg + FW'(1);
            if (cmd.div_start)
                div_cnt_reg <= DCNT_W'(SUM_W);
            else if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
            if (cmd.out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* rtl/cascaded_interval_load_statistics.sv */
`timescale 1ns / 1ps
`default_nettype none

// Keeps load statistics over four nested rings (pulse, second, minute, hour) held in one
// single-port-read memory. An operation of 0 logs the sample (last value, peak, threshold hit
// counters, pulse ring write, and a cascade into the next ring on each wrap); 1 only reports.
// Every word returns the selected ring's count, truncated average, minimum and maximum plus
// last sample, peak and one hit counter. A report walks the selected ring's filled entries:
// the memory read port walks one entry a cycle and a bit-serial divider forms the mean one
// quotient bit a cycle. Each cascade step of a logged sample adds another walk and divide.
// A result waits in an output register while the next word is accepted.
module cascaded_interval_load_statistics #(
    parameter int PULSE_DEPTH  = cils_pkg::DEF_PULSE_DEPTH,
    parameter int SECOND_DEPTH = cils_pkg::DEF_SECOND_DEPTH,
    parameter int MINUTE_DEPTH = cils_pkg::DEF_MINUTE_DEPTH,
    parameter int HOUR_DEPTH   = cils_pkg::DEF_HOUR_DEPTH,
    parameter int SAMPLE_BITS  = cils_pkg::DEF_SAMPLE_BITS,
    parameter int COUNTER_BITS = cils_pkg::DEF_COUNTER_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // sample[15:0], level[17:16], threshold_index[21:18], zero pad
    input  wire logic [cils_pkg::IN_DATA_W-1:0]  s_tdata,
    // operation[0]
    input  wire logic [cils_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // level_count[5:0], level_average[21:6], level_minimum[37:22], level_maximum[53:38],
    // last_sample[69:54], peak_sample[85:70], threshold_hits[117:86], zero pad
    output logic [cils_pkg::OUT_DATA_W-1:0]      m_tdata
);

    cils_pkg::cmd_t    cmd;
    cils_pkg::status_t st;

    cils_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    cils_dp #(
        .PULSE_DEPTH  (PULSE_DEPTH),
        .SECOND_DEPTH (SECOND_DEPTH),
        .MINUTE_DEPTH (MINUTE_DEPTH),
        .HOUR_DEPTH   (HOUR_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
